/* design/qfs_pkg.sv */
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared types, constants and match helpers for the quoted field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package qfs_pkg;

   // character and slot geometry
   localparam int CHAR_BITS   = 16;
   localparam int SEP_SLOTS   = 4;
   localparam int QUOTE_SLOTS = 4;
   localparam int MAX_SLOTS   = 8;
   localparam int PACK_BITS   = 64;

   // result fields
   localparam int KIND_BITS  = 2;
   localparam int FIELD_BITS = 8;
   localparam int COUNT_BITS = 3;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEP_CHARS   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEP_COUNT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUOTE_CHARS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUOTE_COUNT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SINGLE_SEP  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FIELDS  = 3'd5;

   // result kinds
   localparam logic [KIND_BITS-1:0] KIND_CHAR      = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FIELD_END = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_LINE_END  = 2'd2;

   // queue between classifier and parser
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [PACK_BITS-1:0]  sep_chars;
      logic [COUNT_BITS-1:0] sep_count;
      logic [PACK_BITS-1:0]  quote_chars;
      logic [COUNT_BITS-1:0] quote_count;
      logic                  single_sep;
      logic [FIELD_BITS-1:0] max_fields;
   } cfg_type;

   // classified character as it sits in the queue
   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 eol;
      logic                 is_sep;
      logic                 is_quote;
   } item_type;

   typedef enum logic [4:0] {
      MODE_NORMAL  = 5'b00001,
      MODE_QUOTED  = 5'b00010,
      MODE_AFTERQ  = 5'b00100,
      MODE_SKIPSEP = 5'b01000,
      MODE_DONE    = 5'b10000
   } mode_type;

   // true when c matches one of the first min(count, slots) packed slots
   function automatic logic in_set(input logic [CHAR_BITS-1:0]  c,
                                   input logic [PACK_BITS-1:0]  packed_chars,
                                   input logic [COUNT_BITS-1:0] count,
                                   input int                    slots);
      logic                 hit;
      logic [PACK_BITS-1:0] shifted;
      hit = 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         // slots past the packed word shift out to zero
         shifted = packed_chars >> (i * CHAR_BITS);
         if ((i < slots) && (i < int'(count)) && (shifted[CHAR_BITS-1:0] == c)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

/* design/qfs_channels.sv */
// ----------------------------------------------------------------------------
// qfs channels
// Valid/ready channel interfaces for characters in and parse results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface qfs_req_if;
   logic                          valid;
   logic                          ready;
   logic [qfs_pkg::CHAR_BITS-1:0] char_code;
   logic                          end_of_line;

   modport source (output valid, output char_code, output end_of_line, input ready);
   modport sink (input valid, input char_code, input end_of_line, output ready);
endinterface

interface qfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [qfs_pkg::CHAR_BITS-1:0]  out_char;
   logic [qfs_pkg::KIND_BITS-1:0]  kind;
   logic [qfs_pkg::FIELD_BITS-1:0] field_number;
   logic                           last_of_line;

   modport source (output valid, output out_char, output kind, output field_number,
                   output last_of_line, input ready);
   modport sink (input valid, input out_char, input kind, input field_number,
                 input last_of_line, output ready);
endinterface

`default_nettype wire

/* design/qfs_front.sv */
// ----------------------------------------------------------------------------
// qfs_front
// Accepts characters and tags each one as separator and/or quote.
// ----------------------------------------------------------------------------
`default_nettype none

module qfs_front (
   qfs_req_if.sink          req_chan,
   input  qfs_pkg::cfg_type cfg,
   output logic             push_valid,
   output qfs_pkg::item_type push_item,
   input  logic             push_ready
);

   // parallel compare against both character sets
   always_comb begin
      push_item.char_code = req_chan.char_code;
      push_item.eol       = req_chan.end_of_line;
      push_item.is_sep    = qfs_pkg::in_set(req_chan.char_code, cfg.sep_chars,
                                            cfg.sep_count, qfs_pkg::SEP_SLOTS);
      push_item.is_quote  = qfs_pkg::in_set(req_chan.char_code, cfg.quote_chars,
                                            cfg.quote_count, qfs_pkg::QUOTE_SLOTS);
   end

   // queue space gates the input channel
   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

`default_nettype wire

/* design/qfs_queue.sv */
// ----------------------------------------------------------------------------
// qfs_queue
// Short queue of classified characters between classifier and parser.
// ----------------------------------------------------------------------------
`default_nettype none

module qfs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  qfs_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output qfs_pkg::item_type pop_item,
   input  logic              pop_ready
);

   qfs_pkg::item_type                        entry_ff [qfs_pkg::QUEUE_DEPTH];
   logic [qfs_pkg::QUEUE_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [qfs_pkg::QUEUE_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [qfs_pkg::QUEUE_COUNT_BITS-1:0]     count_ff, count_in;
   logic                                     push, pop;

   localparam logic [qfs_pkg::QUEUE_COUNT_BITS-1:0] FULL_COUNT =
      qfs_pkg::QUEUE_COUNT_BITS'(qfs_pkg::QUEUE_DEPTH);
   localparam logic [qfs_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      qfs_pkg::QUEUE_PTR_BITS'(qfs_pkg::QUEUE_DEPTH - 1);

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* design/qfs_back.sv */
// ----------------------------------------------------------------------------
// qfs_back
// Field parser: runs the quote/separator state machine on classified
// characters and holds one result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qfs_back (
   input  logic              clock,
   input  logic              reset,
   input  qfs_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   input  qfs_pkg::item_type pop_item,
   output logic              pop_ready,
   qfs_rsp_if.source         rsp_chan
);

   qfs_pkg::mode_type                 mode_ff, mode_in;
   logic [qfs_pkg::FIELD_BITS-1:0]    count_ff, count_in;
   logic                              has_chars_ff, has_chars_in;

   logic                              out_valid_ff, out_valid_in;
   logic [qfs_pkg::CHAR_BITS-1:0]     out_char_ff, out_char_in;
   logic [qfs_pkg::KIND_BITS-1:0]     kind_ff, kind_in;
   logic [qfs_pkg::FIELD_BITS-1:0]    field_ff, field_in;
   logic                              last_ff, last_in;

   logic                              take;
   logic                              emit;
   logic                              eff_normal;
   logic                              eff_quoted;
   logic                              reaches_max;

   // a new item is taken when the output register is free or being emptied
   assign take      = pop_valid && (!out_valid_ff || rsp_chan.ready);
   assign pop_ready = !out_valid_ff || rsp_chan.ready;

   assign eff_quoted  = (mode_ff == qfs_pkg::MODE_QUOTED);
   assign eff_normal  = (mode_ff == qfs_pkg::MODE_NORMAL) ||
                        ((mode_ff == qfs_pkg::MODE_SKIPSEP) && !pop_item.is_sep);
   assign reaches_max = ({1'b0, count_ff} + 9'd1) >= {1'b0, cfg.max_fields};

   // parse step for the item at the head of the queue
   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      has_chars_in = has_chars_ff;
      emit         = 1'b0;
      out_char_in  = '0;
      kind_in      = qfs_pkg::KIND_CHAR;
      field_in     = count_ff;
      last_in      = 1'b0;

      priority if (pop_item.eol) begin
         mode_in      = qfs_pkg::MODE_NORMAL;
         count_in     = '0;
         has_chars_in = 1'b0;
         if (mode_ff != qfs_pkg::MODE_DONE) begin
            emit    = 1'b1;
            last_in = 1'b1;
            kind_in = (!has_chars_ff || (mode_ff == qfs_pkg::MODE_AFTERQ)) ?
                      qfs_pkg::KIND_LINE_END : qfs_pkg::KIND_FIELD_END;
         end
      end else if (mode_ff == qfs_pkg::MODE_DONE) begin
         has_chars_in = 1'b1;
      end else if (mode_ff == qfs_pkg::MODE_AFTERQ) begin
         // drop up to the next separator
         has_chars_in = 1'b1;
         if (pop_item.is_sep) begin
            mode_in = cfg.single_sep ? qfs_pkg::MODE_NORMAL : qfs_pkg::MODE_SKIPSEP;
         end
      end else if ((mode_ff == qfs_pkg::MODE_SKIPSEP) && pop_item.is_sep) begin
         has_chars_in = 1'b1;
      end else if ((eff_quoted && pop_item.is_quote) || (eff_normal && pop_item.is_sep)) begin
         // field ends
         has_chars_in = 1'b1;
         count_in     = count_ff + 1'b1;
         emit         = 1'b1;
         kind_in      = qfs_pkg::KIND_FIELD_END;
         if (reaches_max) begin
            mode_in = qfs_pkg::MODE_DONE;
            last_in = 1'b1;
         end else if (eff_quoted) begin
            mode_in = qfs_pkg::MODE_AFTERQ;
         end else begin
            mode_in = cfg.single_sep ? qfs_pkg::MODE_NORMAL : qfs_pkg::MODE_SKIPSEP;
         end
      end else if (eff_normal && pop_item.is_quote) begin
         has_chars_in = 1'b1;
         mode_in      = qfs_pkg::MODE_QUOTED;
      end else begin
         // content character
         has_chars_in = 1'b1;
         emit         = 1'b1;
         out_char_in  = pop_item.char_code;
         mode_in      = eff_normal ? qfs_pkg::MODE_NORMAL : mode_ff;
      end
   end

   // output register occupancy
   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = emit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= qfs_pkg::MODE_NORMAL;
         count_ff     <= '0;
         has_chars_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            mode_ff      <= mode_in;
            count_ff     <= count_in;
            has_chars_ff <= has_chars_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take && emit) begin
         out_char_ff <= out_char_in;
         kind_ff     <= kind_in;
         field_ff    <= field_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_char     = out_char_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.field_number = field_ff;
   assign rsp_chan.last_of_line = last_ff;

   // line state is back at its start after an end-of-line transaction
   a_eol_clears_line: assert property (@(posedge clock) disable iff (reset)
      (take && pop_item.eol) |=>
         (mode_ff == qfs_pkg::MODE_NORMAL) && (count_ff == '0) && !has_chars_ff)
      else $error("line state not cleared after end of line");

   // once the field limit is hit, characters give no result
   a_done_is_silent: assert property (@(posedge clock) disable iff (reset)
      (take && !pop_item.eol && (mode_ff == qfs_pkg::MODE_DONE)) |-> !emit)
      else $error("result produced after field limit");

   // non-content results carry no character
   a_marker_zero_char: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (kind_ff != qfs_pkg::KIND_CHAR)) |-> (out_char_ff == '0))
      else $error("field or line marker carries a character");

   // a line end without a field always closes the line
   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (kind_ff == qfs_pkg::KIND_LINE_END)) |-> last_ff)
      else $error("line end marker without last flag");

endmodule

`default_nettype wire

/* design/quoted_field_splitter.sv */
// ----------------------------------------------------------------------------
// quoted_field_splitter
// Splits a character stream into fields at configurable separators, with
// configurable quoting, one character per cycle while rsp_chan.ready stays high.
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one character per transaction, or an end-of-line marker
//   (end_of_line high, char_code ignored). rsp_chan returns zero or one result
//   per transaction: a content character, a field end or a bare line end,
//   tagged with its field number and a last-of-line flag.
//   csr_* writes the separator set, quote set, collapse mode and field limit;
//   write only while no transaction is in flight.
// timing
//   one transaction per cycle sustained while rsp_chan.ready stays high; an
//   accepted character is first written into the two-entry queue, and the
//   parse step then writes its result into the result register, from which
//   its result transaction completes.
// reset
//   synchronous; registers return to the comma separator, no quoting, single
//   separator mode and a field limit of 255, and the queue empties.
// stalls
//   a held result blocks the parser only while rsp_chan.ready is low; the
//   queue keeps req_chan.ready high until both of its entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_field_splitter (
   input  logic                                 clock,
   input  logic                                 reset,
   qfs_req_if.sink                              req_chan,
   qfs_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [qfs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [qfs_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   qfs_pkg::cfg_type  cfg_ff;
   logic              push_valid;
   logic              push_ready;
   qfs_pkg::item_type push_item;
   logic              pop_valid;
   logic              pop_ready;
   qfs_pkg::item_type pop_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sep_chars   <= 64'd44;
         cfg_ff.sep_count   <= 3'd1;
         cfg_ff.quote_chars <= 64'd34;
         cfg_ff.quote_count <= 3'd0;
         cfg_ff.single_sep  <= 1'b1;
         cfg_ff.max_fields  <= 8'd255;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            qfs_pkg::CSR_SEP_CHARS:   cfg_ff.sep_chars   <= csr_write_data;
            qfs_pkg::CSR_SEP_COUNT:   cfg_ff.sep_count   <= csr_write_data[2:0];
            qfs_pkg::CSR_QUOTE_CHARS: cfg_ff.quote_chars <= csr_write_data;
            qfs_pkg::CSR_QUOTE_COUNT: cfg_ff.quote_count <= csr_write_data[2:0];
            qfs_pkg::CSR_SINGLE_SEP:  cfg_ff.single_sep  <= csr_write_data[0];
            qfs_pkg::CSR_MAX_FIELDS:  cfg_ff.max_fields  <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // classifier
   qfs_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // decoupling queue
   qfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // parser and result register
   qfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
